// ===== rtl/mrq_pkg.sv =====
// Shared types and constants of the multilevel priority run queue.
package mrq_pkg;

   localparam int NTHR   = 256;
   localparam int NLVL   = 64;
   localparam int TID_W  = $clog2(NTHR);
   localparam int LVL_W  = $clog2(NLVL);
   localparam int LINK_W = TID_W + 1;
   localparam int CNT_W  = $clog2(NTHR + 1);
   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NTHR);

   typedef enum logic [1:0] {
      REQ_INS_TAIL = 2'd0,
      REQ_INS_HEAD = 2'd1,
      REQ_REMOVE   = 2'd2,
      REQ_PEEK     = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_QUEUED  = 2'd1,
      ST_NOT_Q   = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   // Classified request as it travels from front to back.
   typedef struct packed {
      logic              is_peek;
      logic              is_remove;
      logic              at_head;
      logic [TID_W-1:0]  tid;
      logic [LVL_W-1:0]  lvl;
   } item_type;

endpackage

// ===== rtl/multilevel_priority_run_queue.sv =====
// Top level of the multilevel priority run queue.
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  req     | req_valid/ready    | req_type, req_thread_id, req_priority_req
//  rsp     | rsp_valid/ready    | rsp_status, rsp_first_thread,
//          |                    | rsp_first_priority, rsp_queued_count
//
// In the back-end sequencer the memories have a registered read, so a link
// update reads the links in the issue state and writes them in the execute state,
// and a non-empty insert needs a second write to the neighbor's link.
// Reset clears in-queue marks, the non-empty bitmap and the count at once;
// no clearing pass. A two-entry request queue keeps accepting transfers, until full,
// while a response waits; the back end stalls only on a full response slot.
module multilevel_priority_run_queue import mrq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_type,
   input  logic [TID_W-1:0] req_thread_id,
   input  logic [LVL_W-1:0] req_priority_req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [TID_W-1:0] rsp_first_thread,
   output logic [LVL_W-1:0] rsp_first_priority,
   output logic [CNT_W-1:0] rsp_queued_count
);
   logic     pop_valid, pop_ready;
   item_type pop_item;

   mrq_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_thread_id,
      .req_priority_req, .pop_valid, .pop_ready, .pop_item);

   mrq_back u_back (
      .clock, .reset, .pop_valid, .pop_ready, .pop_item, .rsp_valid, .rsp_ready,
      .rsp_status, .rsp_first_thread, .rsp_first_priority, .rsp_queued_count);

   // count never exceeds the thread space
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_queued_count <= CNT_W'(NTHR))
      else $error("queued count out of range");

   // only an ok peek carries a thread
   a_thread_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_first_thread == '0 && rsp_first_priority == '0)
      else $error("thread reported on a failed request");

   // an empty peek means nothing is queued
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_queued_count == '0)
      else $error("empty peek with threads queued");
endmodule

// ===== rtl/mrq_ram.sv =====
// Generic single-port-write, registered-read RAM.
module mrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/mrq_front.sv =====
// Front end: takes requests, decodes them, holds them in a two-entry queue.
module mrq_front import mrq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_type,
   input  logic [TID_W-1:0] req_thread_id,
   input  logic [LVL_W-1:0] req_priority_req,
   output logic             pop_valid,
   input  logic             pop_ready,
   output item_type         pop_item
);
   item_type   slot_ff [2];
   logic       rd_ptr_ff, wr_ptr_ff;
   logic [1:0] fill_ff;
   item_type   dec;
   logic       push, pop;

   always_comb begin
      dec           = '0;
      dec.tid       = req_thread_id;
      dec.lvl       = req_priority_req;
      case (req_kind_type'(req_type))
         REQ_PEEK:     dec.is_peek   = 1'b1;
         REQ_REMOVE:   dec.is_remove = 1'b1;
         REQ_INS_HEAD: dec.at_head   = 1'b1;
         default:      dec.at_head   = 1'b0;
      endcase
   end

   assign req_ready = (fill_ff != 2'd2);
   assign pop_valid = (fill_ff != 2'd0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ===== rtl/mrq_back.sv =====
// Back end: list update sequencer over the link and level-pointer memories.
module mrq_back import mrq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  item_type         pop_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [TID_W-1:0] rsp_first_thread,
   output logic [LVL_W-1:0] rsp_first_priority,
   output logic [CNT_W-1:0] rsp_queued_count
);
   typedef enum logic [2:0] {
      S_IDLE, S_ISSUE, S_EXEC, S_LINK2, S_DONE
   } state_type;

   state_type         state_ff;
   item_type          item_ff;
   logic [NTHR-1:0]   mark_ff;
   logic [NLVL-1:0]   map_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [LVL_W-1:0]  top_ff;
   logic [LINK_W-1:0] link_ff;
   status_type        status_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [TID_W-1:0]  rsp_thr_ff;
   logic [LVL_W-1:0]  rsp_pri_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   // memory ports
   logic nx_we, pv_we, lv_we, hd_we, tl_we;
   logic [TID_W-1:0]  nx_wa, pv_wa;
   logic [LINK_W-1:0] nx_wd, pv_wd, hd_wd, tl_wd;
   logic [LVL_W-1:0]  hd_wa, hd_ra;
   logic [LINK_W-1:0] nx_rd, pv_rd, hd_rd, tl_rd;
   logic [LVL_W-1:0]  lv_rd;

   logic [LVL_W-1:0]  top;
   logic [TID_W-1:0]  tid;
   logic [LVL_W-1:0]  lvl;
   logic [LINK_W-1:0] tid_link;
   logic              slot_free;

   assign tid       = item_ff.tid;
   assign lvl       = item_ff.lvl;
   assign tid_link  = {1'b0, tid};
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == S_IDLE);

   // highest non-empty level
   always_comb begin
      top = '0;
      for (int i = 0; i < NLVL; i++) begin
         if (map_ff[i]) top = LVL_W'(i);
      end
   end

   assign hd_ra = item_ff.is_peek ? top : lvl;

   always_comb begin
      nx_we = 1'b0; pv_we = 1'b0; lv_we = 1'b0; hd_we = 1'b0; tl_we = 1'b0;
      nx_wa = tid;  pv_wa = tid;  hd_wa = lvl;
      nx_wd = NIL_LINK; pv_wd = NIL_LINK; hd_wd = tid_link; tl_wd = tid_link;
      case (state_ff)
         S_ISSUE: begin
            if (!item_ff.is_peek && !item_ff.is_remove && !mark_ff[tid] && !map_ff[lvl]) begin
               nx_we = 1'b1; pv_we = 1'b1; lv_we = 1'b1; hd_we = 1'b1; tl_we = 1'b1;
            end
         end
         S_EXEC: begin
            if (item_ff.is_remove) begin
               if (lv_rd == lvl) begin
                  hd_wd = nx_rd;
                  tl_wd = pv_rd;
                  hd_we = (pv_rd == NIL_LINK);
                  nx_we = (pv_rd != NIL_LINK);
                  nx_wa = pv_rd[TID_W-1:0];
                  nx_wd = nx_rd;
                  tl_we = (nx_rd == NIL_LINK);
                  pv_we = (nx_rd != NIL_LINK);
                  pv_wa = nx_rd[TID_W-1:0];
                  pv_wd = pv_rd;
               end
            end else if (!item_ff.is_peek) begin
               nx_we = 1'b1; pv_we = 1'b1; lv_we = 1'b1;
               if (item_ff.at_head) begin
                  nx_wd = hd_rd;
                  hd_we = 1'b1;
               end else begin
                  pv_wd = tl_rd;
                  tl_we = 1'b1;
               end
            end
         end
         S_LINK2: begin
            if (item_ff.at_head) begin
               pv_we = 1'b1;
               pv_wa = link_ff[TID_W-1:0];
               pv_wd = tid_link;
            end else begin
               nx_we = 1'b1;
               nx_wa = link_ff[TID_W-1:0];
               nx_wd = tid_link;
            end
         end
         default: ;
      endcase
   end

   mrq_ram #(.WIDTH(LINK_W), .DEPTH(NTHR)) u_next (
      .clock, .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd), .rd_addr(tid), .rd_data(nx_rd));
   mrq_ram #(.WIDTH(LINK_W), .DEPTH(NTHR)) u_prev (
      .clock, .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd), .rd_addr(tid), .rd_data(pv_rd));
   mrq_ram #(.WIDTH(LVL_W), .DEPTH(NTHR)) u_level (
      .clock, .wr_en(lv_we), .wr_addr(tid), .wr_data(lvl), .rd_addr(tid), .rd_data(lv_rd));
   mrq_ram #(.WIDTH(LINK_W), .DEPTH(NLVL)) u_head (
      .clock, .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd), .rd_addr(hd_ra), .rd_data(hd_rd));
   mrq_ram #(.WIDTH(LINK_W), .DEPTH(NLVL)) u_tail (
      .clock, .wr_en(tl_we), .wr_addr(lvl), .wr_data(tl_wd), .rd_addr(lvl), .rd_data(tl_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mark_ff      <= '0;
         map_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop_valid) begin
                  item_ff  <= pop_item;
                  state_ff <= S_ISSUE;
               end
            end
            S_ISSUE: begin
               top_ff <= top;
               if (item_ff.is_peek) begin
                  if (map_ff == '0) begin
                     status_ff <= ST_EMPTY;
                     state_ff  <= S_DONE;
                  end else begin
                     status_ff <= ST_OK;
                     state_ff  <= S_EXEC;
                  end
               end else if (item_ff.is_remove) begin
                  if (!mark_ff[tid]) begin
                     status_ff <= ST_NOT_Q;
                     state_ff  <= S_DONE;
                  end else begin
                     status_ff <= ST_OK;
                     state_ff  <= S_EXEC;
                  end
               end else if (mark_ff[tid]) begin
                  status_ff <= ST_QUEUED;
                  state_ff  <= S_DONE;
               end else if (!map_ff[lvl]) begin
                  status_ff    <= ST_OK;
                  mark_ff[tid] <= 1'b1;
                  map_ff[lvl]  <= 1'b1;
                  count_ff     <= count_ff + 1'b1;
                  state_ff     <= S_DONE;
               end else begin
                  status_ff <= ST_OK;
                  state_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (item_ff.is_peek) begin
                  link_ff  <= hd_rd;
                  state_ff <= S_DONE;
               end else if (item_ff.is_remove) begin
                  state_ff <= S_DONE;
                  if (lv_rd != lvl) begin
                     status_ff <= ST_NOT_Q;
                  end else begin
                     mark_ff[tid] <= 1'b0;
                     if (pv_rd == NIL_LINK && nx_rd == NIL_LINK) map_ff[lvl] <= 1'b0;
                     if (count_ff != '0) count_ff <= count_ff - 1'b1;
                  end
               end else begin
                  link_ff      <= item_ff.at_head ? hd_rd : tl_rd;
                  mark_ff[tid] <= 1'b1;
                  count_ff     <= count_ff + 1'b1;
                  state_ff     <= S_LINK2;
               end
            end
            S_LINK2: state_ff <= S_DONE;
            S_DONE: begin
               if (slot_free) begin
                  rsp_status_ff <= status_ff;
                  rsp_cnt_ff    <= count_ff;
                  if (item_ff.is_peek && status_ff == ST_OK) begin
                     rsp_thr_ff <= link_ff[TID_W-1:0];
                     rsp_pri_ff <= top_ff;
                  end else begin
                     rsp_thr_ff <= '0;
                     rsp_pri_ff <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_first_thread   = rsp_thr_ff;
   assign rsp_first_priority = rsp_pri_ff;
   assign rsp_queued_count   = rsp_cnt_ff;
endmodule

// ===== tb/sv/multilevel_priority_run_queue_tb.sv =====
// Testbench for the multilevel priority run queue, checked against a local shadow queue.
`timescale 1ns / 1ps
module multilevel_priority_run_queue_tb import mrq_pkg::*; ();

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_type = REQ_PEEK;
   logic [TID_W-1:0] req_thread_id = '0;
   logic [LVL_W-1:0] req_priority_req = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [1:0]       rsp_status;
   logic [TID_W-1:0] rsp_first_thread;
   logic [LVL_W-1:0] rsp_first_priority;
   logic [CNT_W-1:0] rsp_queued_count;

   multilevel_priority_run_queue u_top (.*);

   initial forever #5 clock = ~clock;

   // One expected response.
   typedef struct {
      logic [1:0]       status;
      logic [TID_W-1:0] thr;
      logic [LVL_W-1:0] pri;
      logic [CNT_W-1:0] cnt;
   } rsp_exp_type;

   rsp_exp_type exp_rsp_q[$];
   int          fail_count = 0;

   // Shadow run queue. Null link coded as NTHR.
   logic [LINK_W-1:0] sh_next[NTHR];
   logic [LINK_W-1:0] sh_prev[NTHR];
   logic              sh_mark[NTHR];
   logic [LVL_W-1:0]  sh_lvl[NTHR];
   logic [LINK_W-1:0] sh_head[NLVL];
   logic [LINK_W-1:0] sh_tail[NLVL];
   int                sh_total;

   // Receiver hold-off, in cycles; set by the pressure test.
   int rsp_hold = 0;
   bit rsp_idle_en = 1'b1;
   bit req_idle_en = 1'b1;

   function automatic void queue_clear();
      for (int i = 0; i < NTHR; i++) begin
         sh_next[i] = NIL_LINK;
         sh_prev[i] = NIL_LINK;
         sh_mark[i] = 1'b0;
         sh_lvl[i]  = '0;
      end
      for (int i = 0; i < NLVL; i++) begin
         sh_head[i] = NIL_LINK;
         sh_tail[i] = NIL_LINK;
      end
      sh_total = 0;
   endfunction

   // Apply one request to the shadow queue and return its response.
   function automatic rsp_exp_type queue_apply(logic [1:0] kind, logic [TID_W-1:0] tid,
                                               logic [LVL_W-1:0] lvl);
      rsp_exp_type r;
      logic [LINK_W-1:0] nx, pv;
      int top;
      r = '{ST_OK, '0, '0, '0};
      top = -1;
      if (kind == REQ_PEEK) begin
         for (int l = NLVL - 1; l >= 0; l--)
            if (sh_head[l] != NIL_LINK && top < 0) top = l;
         if (top < 0) r.status = ST_EMPTY;
         else begin
            r.thr = sh_head[top][TID_W-1:0];
            r.pri = LVL_W'(top);
         end
      end else if (kind == REQ_REMOVE) begin
         if (!sh_mark[tid] || sh_lvl[tid] != lvl) r.status = ST_NOT_Q;
         else begin
            nx = sh_next[tid];
            pv = sh_prev[tid];
            if (pv == NIL_LINK) sh_head[lvl] = nx;
            else sh_next[pv[TID_W-1:0]] = nx;
            if (nx == NIL_LINK) sh_tail[lvl] = pv;
            else sh_prev[nx[TID_W-1:0]] = pv;
            sh_next[tid] = NIL_LINK;
            sh_prev[tid] = NIL_LINK;
            sh_mark[tid] = 1'b0;
            sh_total--;
         end
      end else if (sh_mark[tid]) begin
         r.status = ST_QUEUED;
      end else begin
         if (sh_head[lvl] == NIL_LINK) begin
            sh_next[tid] = NIL_LINK;
            sh_prev[tid] = NIL_LINK;
            sh_head[lvl] = {1'b0, tid};
            sh_tail[lvl] = {1'b0, tid};
         end else if (kind == REQ_INS_TAIL) begin
            sh_prev[tid] = sh_tail[lvl];
            sh_next[tid] = NIL_LINK;
            sh_next[sh_tail[lvl][TID_W-1:0]] = {1'b0, tid};
            sh_tail[lvl] = {1'b0, tid};
         end else begin
            sh_next[tid] = sh_head[lvl];
            sh_prev[tid] = NIL_LINK;
            sh_prev[sh_head[lvl][TID_W-1:0]] = {1'b0, tid};
            sh_head[lvl] = {1'b0, tid};
         end
         sh_mark[tid] = 1'b1;
         sh_lvl[tid]  = lvl;
         sh_total++;
      end
      r.cnt = CNT_W'(sh_total);
      return r;
   endfunction

   // Send one request: idle gap, then hold valid until the transfer.
   // Valid stays high into the next request when it follows with no gap.
   task automatic send_req(logic [1:0] kind, logic [TID_W-1:0] tid, logic [LVL_W-1:0] lvl);
      int gap;
      gap = req_idle_en ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_thread_id    <= tid;
      req_priority_req <= lvl;
      do @(posedge clock); while (!req_ready);
      exp_rsp_q.push_back(queue_apply(kind, tid, lvl));
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (exp_rsp_q.size() != 0) @(negedge clock);
   endtask

   // Receiver: random stall per response, plus an optional long hold-off.
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         gap = rsp_idle_en ? $urandom_range(0, 13) : 0;
         if (rsp_hold > 0 || gap > 0) begin
            rsp_ready <= 1'b0;
            if (rsp_hold > 0) begin
               repeat (rsp_hold) @(negedge clock);
               rsp_hold = 0;
            end
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Response checker.
   always @(posedge clock) begin
      rsp_exp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_rsp_q.size() == 0) begin
            $error("response with nothing expected");
            fail_count++;
         end else begin
            e = exp_rsp_q.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); fail_count++;
            end
            if (rsp_first_thread !== e.thr) begin
               $error("first_thread exp %0d got %0d", e.thr, rsp_first_thread);
               fail_count++;
            end
            if (rsp_first_priority !== e.pri) begin
               $error("first_priority exp %0d got %0d", e.pri, rsp_first_priority);
               fail_count++;
            end
            if (rsp_queued_count !== e.cnt) begin
               $error("queued_count exp %0d got %0d", e.cnt, rsp_queued_count);
               fail_count++;
            end
         end
      end
   end

   // Directed: extremes, every request kind, each error status.
   task automatic test_directed();
      send_req(REQ_PEEK, 8'd0, 6'd0);          // peek on empty queue
      send_req(REQ_REMOVE, 8'd5, 6'd3);        // remove of unqueued thread
      send_req(REQ_INS_TAIL, 8'd0, 6'd0);
      send_req(REQ_INS_TAIL, 8'd255, 6'd63);
      send_req(REQ_PEEK, 8'hAA, 6'h15);
      send_req(REQ_INS_TAIL, 8'd255, 6'd0);    // double insert
      send_req(REQ_INS_HEAD, 8'd0, 6'd63);     // double insert, head form
      send_req(REQ_INS_HEAD, 8'd17, 6'd63);
      send_req(REQ_PEEK, 8'd0, 6'd0);
      send_req(REQ_INS_TAIL, 8'd18, 6'd63);
      send_req(REQ_REMOVE, 8'd17, 6'd62);      // wrong level
      send_req(REQ_REMOVE, 8'd255, 6'd63);     // middle of list
      send_req(REQ_REMOVE, 8'd17, 6'd63);      // head
      send_req(REQ_PEEK, 8'd0, 6'd0);
      send_req(REQ_REMOVE, 8'd18, 6'd63);      // last one in level
      send_req(REQ_PEEK, 8'd0, 6'd0);
      send_req(REQ_REMOVE, 8'd0, 6'd0);
      send_req(REQ_PEEK, 8'd0, 6'd0);
      wait_drain();
   endtask

   // Random mix: mostly valid inserts/removes of queued threads.
   task automatic test_random(int n);
      logic [TID_W-1:0] tid;
      logic [LVL_W-1:0] lvl;
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         tid = $urandom_range(0, 255);
         lvl = (k % 3 == 0) ? LVL_W'($urandom_range(0, 63)) : LVL_W'($urandom_range(0, 7));
         if (k < 35) send_req(REQ_INS_TAIL, tid, lvl);
         else if (k < 55) send_req(REQ_INS_HEAD, tid, lvl);
         else if (k < 75) send_req(REQ_REMOVE, tid, sh_mark[tid] ? sh_lvl[tid] : lvl);
         else if (k < 82) send_req(REQ_REMOVE, tid, lvl);
         else send_req(REQ_PEEK, tid, lvl);
      end
   endtask

   // Long receiver hold-off while requests keep coming, then a full drain.
   task automatic test_backpressure();
      rsp_hold = 200;
      req_idle_en = 1'b0;
      test_random(30);
      req_idle_en = 1'b1;
      wait_drain();
   endtask

   // Fill the queue to all 256 threads and empty it again.
   task automatic test_fill();
      for (int i = 0; i < NTHR; i++)
         send_req(REQ_INS_TAIL, TID_W'(i), LVL_W'(i % 4));
      send_req(REQ_PEEK, 8'd0, 6'd0);
      for (int i = 0; i < NTHR; i++)
         send_req(REQ_REMOVE, TID_W'(i), sh_lvl[i]);
      wait_drain();
   endtask

   initial begin
      queue_clear();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      rsp_idle_en = 1'b0;
      req_idle_en = 1'b0;
      test_random(200);          // stretch with no idling
      rsp_idle_en = 1'b1;
      req_idle_en = 1'b1;
      test_fill();
      test_random(950);
      wait_drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && exp_rsp_q.size() == 0)
         $display("multilevel_priority_run_queue_tb OK");
      else
         $display("multilevel_priority_run_queue_tb NOT OK");
      $finish;
   end

   // Timeout.
   initial begin
      #5ms;
      $display("multilevel_priority_run_queue_tb NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mrq_pkg.sv
rtl/mrq_ram.sv
rtl/mrq_front.sv
rtl/mrq_back.sv
rtl/multilevel_priority_run_queue.sv
tb/sv/multilevel_priority_run_queue_tb.sv
